### hw/rtl/lfia_pkg.sv
// lfia_pkg: shared types and constants of the lowest-free identifier allocator
// holds the command and result structs, opcode, status and sequencer state codes
// no dependencies
`default_nettype none

package lfia_pkg;

  localparam int LFIA_ID_COUNT = 1024;
  localparam int WORD_W        = 32;
  localparam int WORD_BITS_W   = 5;
  localparam int ID_W          = 10;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_ALLOCATE = 2'd1,
    OP_FREE     = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL_NOW  = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MODIFY,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] id_in;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] id_out;
    logic [1:0]      status;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/lfia_zero_find.sv
// lfia_zero_find: priority encoder that finds the lowest set bit of a bitmap word
// candidate bits mark free identifiers; depends on lfia_pkg
`default_nettype none

module lfia_zero_find
  import lfia_pkg::*;
(
  input  wire logic [WORD_W-1:0]      cand,
  output logic                        found,
  output logic [WORD_BITS_W-1:0]      pos
);

  always_comb begin
    found = 1'b0;
    pos   = '0;
    // walk from the top so the lowest set bit wins
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        pos   = WORD_BITS_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lowest_free_id_allocator.sv
// response: register and free of a pool id answer after the read-modify-write of their word;
// unused opcodes and out-of-range ids answer in the cycle after accept; an allocate with an
// invalid pointer answers in the cycle after accept; a valid allocate answers from the
// read-modify-write or scans onward through the bitmap words up to the last one
// throughput: one transaction at a time, busy stays high through read-modify-write and scan
// reset: synchronous rst, then a clearing pass over all NUM_WORDS words (32 at 1024) with busy high
`default_nettype none

module lowest_free_id_allocator
  import lfia_pkg::*;
#(
  parameter int ID_COUNT = LFIA_ID_COUNT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire cmd_t    cmd,
  output logic         busy,
  output logic         done,
  output result_t      result
);

  // bitmap geometry: 32 identifiers per memory word
  localparam int NUM_WORDS  = (ID_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PW         = $clog2(ID_COUNT + 1);
  localparam int CW         = (PW > ID_W) ? PW : ID_W;
  localparam int LAST_VALID = ID_COUNT - (NUM_WORDS - 1) * WORD_W;
  localparam logic [AW-1:0]     LAST_WORD = AW'(NUM_WORDS - 1);
  localparam logic [WORD_W:0]   LAST_FULL = (33'(1) << LAST_VALID) - 33'(1);
  localparam logic [WORD_W-1:0] LAST_MASK = LAST_FULL[WORD_W-1:0];
  localparam logic [CW-1:0]     COUNT_W   = CW'(ID_COUNT);

  // bitmap memory, one bit per identifier, registered read
  logic [WORD_W-1:0] bitmap [NUM_WORDS];
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      bitmap[waddr] <= wdata;
    end
    rdata <= bitmap[raddr];
  end

  // control and payload registers
  state_t            state, state_next;
  logic [PW-1:0]     ptr, ptr_next;
  cmd_t              cmd_q, cmd_q_next;
  logic [PW-1:0]     given, given_next;
  logic [AW-1:0]     chk_word, chk_word_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;
  logic              done_next;
  result_t           result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      ptr      <= PW'(1);
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q    <= cmd_q_next;
    given    <= given_next;
    chk_word <= chk_word_next;
    result   <= result_next;
  end

  // widened views for compares and slicing
  logic [CW-1:0]          cmd_id_w, q_id_w, ptr_w, given_w, target_w;
  logic [AW-1:0]          tgt_word;
  logic [WORD_W-1:0]      bit_mask;
  logic [WORD_W-1:0]      mod_word;
  logic [WORD_W-1:0]      cand;
  logic [AW-1:0]          cand_word;
  logic [WORD_W-1:0]      valid_mask;
  logic                   zf_found;
  logic [WORD_BITS_W-1:0] zf_pos;

  assign cmd_id_w = CW'(cmd.id_in);
  assign q_id_w   = CW'(cmd_q.id_in);
  assign ptr_w    = CW'(ptr);
  assign given_w  = CW'(given);
  // allocate works on the pointer's identifier, register and free on the command's
  assign target_w = (cmd_q.op == OP_ALLOCATE) ? given_w : q_id_w;
  assign tgt_word = AW'(target_w >> WORD_BITS_W);
  assign bit_mask = WORD_W'(1) << target_w[WORD_BITS_W-1:0];
  assign mod_word = (cmd_q.op == OP_FREE) ? (rdata & ~bit_mask) : (rdata | bit_mask);

  // free candidates: in the modify cycle only bits above the handed-out one,
  // in the scan the whole word; bits past the pool end count as used
  assign cand_word  = (state == S_SCAN) ? chk_word : tgt_word;
  assign valid_mask = (cand_word == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}};
  assign cand = (state == S_SCAN) ? (~rdata & valid_mask)
                                  : (~mod_word & valid_mask & ~(bit_mask - WORD_W'(1)));

  lfia_zero_find u_zero_find (
    .cand  (cand),
    .found (zf_found),
    .pos   (zf_pos)
  );

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    cmd_q_next    = cmd_q;
    given_next    = given;
    chk_word_next = chk_word;
    clr_addr_next = clr_addr;
    done_next     = 1'b0;
    result_next   = '0;
    we            = 1'b0;
    waddr         = clr_addr;
    wdata         = '0;
    raddr         = '0;
    busy          = 1'b1;

    case (state)
      S_CLEAR: begin
        // clearing pass, one word per cycle
        we = 1'b1;
        if (clr_addr == LAST_WORD) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_q_next = cmd;
          given_next = ptr;
          case (cmd.op)
            OP_ALLOCATE: begin
              if (ptr_w < COUNT_W) begin
                raddr      = AW'(ptr_w >> WORD_BITS_W);
                state_next = S_MODIFY;
              end else begin
                // pool exhausted, answer at once
                done_next          = 1'b1;
                result_next.status = ST_EXHAUSTED;
              end
            end
            OP_REGISTER, OP_FREE: begin
              if (cmd_id_w < COUNT_W) begin
                raddr      = AW'(cmd_id_w >> WORD_BITS_W);
                state_next = S_MODIFY;
              end else begin
                // identifier beyond the pool is ignored
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_MODIFY: begin
        // read-modify-write of the target word
        we    = 1'b1;
        waddr = tgt_word;
        wdata = mod_word;
        case (cmd_q.op)
          OP_ALLOCATE: begin
            result_next.id_out = given_w[ID_W-1:0];
            if (zf_found) begin
              ptr_next   = PW'({tgt_word, zf_pos});
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (tgt_word == LAST_WORD) begin
              ptr_next           = PW'(ID_COUNT);
              done_next          = 1'b1;
              result_next.status = ST_FULL_NOW;
              state_next         = S_IDLE;
            end else begin
              // continue with the following words, read one ahead
              raddr         = tgt_word + AW'(1);
              chk_word_next = tgt_word + AW'(1);
              state_next    = S_SCAN;
            end
          end
          OP_FREE: begin
            if (q_id_w < ptr_w) begin
              ptr_next = PW'(q_id_w);
            end
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        result_next.id_out = given_w[ID_W-1:0];
        if (zf_found) begin
          ptr_next   = PW'({chk_word, zf_pos});
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (chk_word == LAST_WORD) begin
          ptr_next           = PW'(ID_COUNT);
          done_next          = 1'b1;
          result_next.status = ST_FULL_NOW;
          state_next         = S_IDLE;
        end else begin
          raddr         = chk_word + AW'(1);
          chk_word_next = chk_word + AW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // pointer is either a pool identifier or the invalid marker
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= PW'(ID_COUNT))
    else $error("next-free pointer beyond pool size");

  // allocate on an invalid pointer answers exhausted in the next cycle
  a_exhausted: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.op == OP_ALLOCATE && ptr_w >= COUNT_W)
    |=> (done && result.status == ST_EXHAUSTED && result.id_out == '0))
    else $error("exhausted allocate not answered");

  // pool-full status leaves the pointer invalid
  a_full_ptr: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL_NOW) |-> (ptr == PW'(ID_COUNT)))
    else $error("full status with valid pointer");

  // results only come while idle after a transaction, never two in a row without accept
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(start && !busy)) |-> (state == S_IDLE && $past(state) != S_IDLE))
    else $error("result without a transaction in flight");
`endif

endmodule

`default_nettype wire
